// ===== rtl/swma_pkg.sv =====
// Constants shared by the sliding-window median alarm.
`default_nettype none
package swma_pkg;

  localparam int unsigned DefWindowSize = 50;
  localparam int unsigned MinSamples    = 5;
  localparam int unsigned SampleW       = 64;
  localparam int unsigned ThreshW       = 16;
  localparam int unsigned CountOutW     = 6;
  localparam logic [ThreshW-1:0] ThreshReset = 16'd16;

endpackage
`default_nettype wire

// ===== rtl/sliding_window_median_alarm.sv =====
// Sliding-window median of clock-offset samples with an out-of-sync alarm.
`default_nettype none
// Each accepted sample enters a ring of the last WINDOW_SIZE samples and a
// sorted copy of the same window. The sorted copy lives in two banks: one pass
// reads the current bank in order and writes the other bank, dropping the
// sample that leaves the ring and merging in the new one, one entry per cycle.
// The upper median (entry count/2 of the sorted window) is caught as it is
// written, and the alarm compare follows in the last cycle. From acceptance
// until the result register is loaded the block steps through PRIME, MERGE
// and FIN in that order; s_axis_tready is low meanwhile. A result waits in the
// output register while the next sample is taken. sample_count reports the
// low six bits of the true count. The alarm threshold is written through the
// cfg channel, which is always ready; the user is to write it between samples,
// which the block itself does not enforce. A sample in progress uses the
// threshold held when its result is formed.
module sliding_window_median_alarm
  import swma_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE = DefWindowSize
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // cfg beat: alarm threshold
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [63:0] offset_sample
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // [63:0] median_offset, [69:64] sample_count
  output logic [1:0]       m_axis_tuser    // [0] enough_samples, [1] out_of_sync
);

  localparam int unsigned CW = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned AW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam logic [CW-1:0] WinCnt = CW'(WINDOW_SIZE);
  localparam logic [CW-1:0] MinCnt = CW'(MinSamples);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PRIME = 2'd1;
  localparam logic [1:0] ST_MERGE = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CW-1:0]       cnt_q, n_old_q, r_q, w_q;
  logic [AW-1:0]       oldest_q, slot_q;
  logic                full_q, ins_q, del_q, bank_q;
  logic [ThreshW-1:0]  thr_q;
  logic [SampleW-1:0]  new_q, med_q;
  logic [SampleW-1:0]  ring_rd_q, rd_a_q, rd_b_q;
  logic                out_vld_q;
  logic [SampleW-1:0]  out_med_q;
  logic [CountOutW-1:0] out_cnt_q;
  logic                out_enough_q, out_oos_q;

  logic [SampleW-1:0]  ring_mem [WINDOW_SIZE];
  logic [SampleW-1:0]  sort_a   [WINDOW_SIZE];
  logic [SampleW-1:0]  sort_b   [WINDOW_SIZE];

  logic                in_acc, out_free;
  logic [CW:0]         slot_sum;
  logic [AW-1:0]       slot_nx;
  logic [SampleW-1:0]  cur;
  logic                cur_vld, take_del, take_ins, take_cur, merge_end;
  logic                wr_en;
  logic [SampleW-1:0]  wr_val;
  logic [CW-1:0]       r_nx;
  logic [AW-1:0]       rd_addr;
  logic                enough;
  logic [SampleW-1:0]  fin_med, fin_clamp, fin_mag;
  logic                fin_oos;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;

  // ring slot for the new sample: the oldest slot once full, else the next free one
  assign slot_sum = {1'b0, CW'(oldest_q)} + {1'b0, cnt_q};
  always_comb begin
    if (cnt_q == WinCnt) begin
      slot_nx = oldest_q;
    end else if (slot_sum >= {1'b0, WinCnt}) begin
      slot_nx = AW'(slot_sum - {1'b0, WinCnt});
    end else begin
      slot_nx = AW'(slot_sum);
    end
  end

  // merge step: drop the leaving sample, insert the new one, copy the rest
  assign cur       = bank_q ? rd_b_q : rd_a_q;
  assign cur_vld   = (r_q < n_old_q);
  assign take_del  = cur_vld && full_q && !del_q && (cur == ring_rd_q);
  assign take_ins  = !take_del && !ins_q && (!cur_vld || ($signed(new_q) < $signed(cur)));
  assign take_cur  = !take_del && !take_ins && cur_vld;
  assign merge_end = !cur_vld && ins_q;
  assign wr_en     = (state_q == ST_MERGE) && (take_ins || take_cur);
  assign wr_val    = take_ins ? new_q : cur;
  assign r_nx      = r_q + CW'(take_del || take_cur);

  always_comb begin
    rd_addr = '0;
    if (state_q == ST_MERGE && r_nx < n_old_q) begin
      rd_addr = r_nx[AW-1:0];
    end
  end

  // result: clamp the most negative value before taking the magnitude
  assign enough    = (cnt_q >= MinCnt);
  assign fin_med   = enough ? med_q : '0;
  assign fin_clamp = (fin_med == {1'b1, {(SampleW-1){1'b0}}}) ?
                     {1'b1, {(SampleW-2){1'b0}}, 1'b1} : fin_med;
  assign fin_mag   = fin_clamp[SampleW-1] ? (~fin_clamp + 1'b1) : fin_clamp;
  assign fin_oos   = (fin_mag > {{(SampleW-ThreshW){1'b0}}, thr_q});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_PRIME;
      ST_PRIME: state_d = ST_MERGE;
      ST_MERGE: if (merge_end) state_d = ST_FIN;
      ST_FIN:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      oldest_q  <= '0;
      n_old_q   <= '0;
      r_q       <= '0;
      w_q       <= '0;
      full_q    <= 1'b0;
      ins_q     <= 1'b0;
      del_q     <= 1'b0;
      bank_q    <= 1'b0;
      thr_q     <= ThreshReset;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      // load a new result beat, else drop the one taken
      if (state_q == ST_FIN && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            full_q <= (cnt_q == WinCnt);
          end
        end
        ST_PRIME: begin
          n_old_q <= cnt_q;
          r_q     <= '0;
          w_q     <= '0;
          ins_q   <= 1'b0;
          del_q   <= 1'b0;
          if (full_q) begin
            oldest_q <= (oldest_q == AW'(WINDOW_SIZE - 1)) ? '0 : oldest_q + 1'b1;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_MERGE: begin
          r_q <= r_nx;
          if (take_ins) ins_q <= 1'b1;
          if (take_del) del_q <= 1'b1;
          if (wr_en) w_q <= w_q + 1'b1;
          if (merge_end) bank_q <= !bank_q;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      new_q  <= s_axis_tdata;
      slot_q <= slot_nx;
    end
    if (wr_en && w_q == (cnt_q >> 1)) begin
      med_q <= wr_val;
    end
    if (state_q == ST_FIN && out_free) begin
      out_med_q    <= fin_med;
      out_cnt_q    <= CountOutW'(cnt_q);
      out_enough_q <= enough;
      out_oos_q    <= fin_oos;
    end
  end

  // ring: read the leaving sample and write the new one in the same cycle
  always_ff @(posedge clk_i) begin
    if (state_q == ST_PRIME) begin
      ring_rd_q          <= ring_mem[oldest_q];
      ring_mem[slot_q]   <= new_q;
    end
  end

  // sorted banks: read one, write the other
  always_ff @(posedge clk_i) begin
    rd_a_q <= sort_a[rd_addr];
    if (wr_en && bank_q) begin
      sort_a[w_q[AW-1:0]] <= wr_val;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_b_q <= sort_b[rd_addr];
    if (wr_en && !bank_q) begin
      sort_b[w_q[AW-1:0]] <= wr_val;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(72-SampleW-CountOutW){1'b0}}, out_cnt_q, out_med_q};
  assign m_axis_tuser  = {out_oos_q, out_enough_q};

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= WinCnt)
    else $error("held count beyond window size");

  a_oldest_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oldest_q < AW'(WINDOW_SIZE) || AW'(WINDOW_SIZE) == '0)
    else $error("oldest slot out of range");

  a_merge_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE && merge_end) |-> (w_q == cnt_q))
    else $error("sorted bank length differs from held count");

  a_merge_del: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE && merge_end && full_q) |-> del_q)
    else $error("leaving sample not found in sorted bank");

  a_zero_median: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[63:0] == '0 && !m_axis_tuser[1]))
    else $error("median or alarm set with too few samples");

endmodule
`default_nettype wire
